[sv/pact_pkg.sv]
// Package for the per-address connect throttle: entry record, register codes,
// reset values and the small arithmetic helpers. No dependencies.
package pact_pkg;

    localparam int DEF_ENTRIES    = 64;
    localparam int DEF_MAX_STAGES = 8;

    // Configuration register indexes.
    localparam logic [2:0] REG_TRIGGER_COUNT = 3'd0;
    localparam logic [2:0] REG_TRIGGER_SPAN  = 3'd1;
    localparam logic [2:0] REG_STAGE_LIMIT   = 3'd2;
    localparam logic [2:0] REG_CACHE_LENGTH  = 3'd3;
    localparam logic [2:0] REG_BASE_BAN_LEN  = 3'd4;

    localparam logic [7:0]  RST_TRIGGER_COUNT = 8'd3;
    localparam logic [15:0] RST_TRIGGER_SPAN  = 16'd15;
    localparam logic [3:0]  RST_STAGE_LIMIT   = 4'd5;
    localparam logic [19:0] RST_CACHE_LENGTH  = 20'd3600;
    localparam logic [15:0] RST_BASE_BAN_LEN  = 16'd180;

    typedef struct packed {
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic [31:0] window_start;
        logic [7:0]  attempt_count;
        logic [31:0] ban_time;
        logic [3:0]  ban_stage;
        logic [31:0] expiry_time;
    } t_entry;

    // Factorial of the stage, with the stage clamped to 1..max_s.
    function automatic logic [15:0] pact_fact(input logic [3:0] s, input logic [3:0] max_s);
        logic [3:0] c;
        logic [15:0] f;
        c = s;
        if (c < 4'd1) c = 4'd1;
        if (c > max_s) c = max_s;
        case (c)
            4'd1:    f = 16'd1;
            4'd2:    f = 16'd2;
            4'd3:    f = 16'd6;
            4'd4:    f = 16'd24;
            4'd5:    f = 16'd120;
            4'd6:    f = 16'd720;
            4'd7:    f = 16'd5040;
            4'd8:    f = 16'd40320;
            default: f = 16'd1;
        endcase
        return f;
    endfunction

    function automatic logic [31:0] pact_sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] r;
        r = {1'b0, a} + {1'b0, b};
        return r[32] ? 32'hFFFF_FFFF : r[31:0];
    endfunction

endpackage

[sv/pact_lenmul.sv]
// Ban length unit: base ban length times the factorial of a stage, registered.
// Depends on pact_pkg.
module pact_lenmul #(
    parameter int MAX_STAGES = pact_pkg::DEF_MAX_STAGES
) (
    input  logic        i_clk,
    input  logic [15:0] i_base,
    input  logic [3:0]  i_stage,
    output logic [31:0] o_len
);
    import pact_pkg::*;

    localparam logic [3:0] MAX_S = 4'(MAX_STAGES);

    logic [31:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= {16'd0, i_base} * {16'd0, pact_fact(i_stage, MAX_S)};
    end

    assign o_len = r_prod;

endmodule

[sv/per_address_connect_throttle.sv]
// Top level of the per-address connect throttle: entry memory, scan pipeline
// and update sequencer. Depends on pact_pkg and pact_lenmul.
//
//  Channel   Direction  Ports              Contents (lowest bit first)
//  request   in         i_s_axis_*         addr_high, addr_low, now
//  result    out        o_m_axis_*         throttled, deny_add, deny_length, stage_now,
//                                          table_full
//  config    in         i_cfg_*            write enable, index, data
//
// A request passes from acceptance to a valid result through the scan, which
// reads every entry once from the entry memory with a two-stage compare behind
// it, then decide, up to three update steps and the output step. The next
// request is taken in the idle state after the output step.
// Reset clears the valid bits at once; no clearing pass is needed.
// A new request is taken once the previous result sits in the output register;
// a stalled output holds the next result in the output step, and no request is taken.
module per_address_connect_throttle #(
    parameter int ENTRIES    = pact_pkg::DEF_ENTRIES,
    parameter int MAX_STAGES = pact_pkg::DEF_MAX_STAGES
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // addr_high[63:0], addr_low[127:64], now[159:128]
    input  logic [159:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // throttled[0], deny_add[1], deny_length[33:2], stage_now[37:34],
    // table_full[38], zero[39]
    output logic [39:0]  o_m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [19:0]  i_cfg_wdata
);
    import pact_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = IDX_W + 1;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(ENTRIES);
    localparam logic [3:0] MAX_S = 4'(MAX_STAGES);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_DEC  = 3'd2;
    localparam logic [2:0] ST_UPD1 = 3'd3;
    localparam logic [2:0] ST_UPD2 = 3'd4;
    localparam logic [2:0] ST_UPD3 = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    // Configuration registers.
    logic [7:0]  r_trig_cnt;
    logic [15:0] r_trig_span;
    logic [3:0]  r_stage_lim;
    logic [19:0] r_cache_len;
    logic [15:0] r_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_cnt  <= RST_TRIGGER_COUNT;
            r_trig_span <= RST_TRIGGER_SPAN;
            r_stage_lim <= RST_STAGE_LIMIT;
            r_cache_len <= RST_CACHE_LENGTH;
            r_base      <= RST_BASE_BAN_LEN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_TRIGGER_COUNT: r_trig_cnt  <= i_cfg_wdata[7:0];
                REG_TRIGGER_SPAN:  r_trig_span <= i_cfg_wdata[15:0];
                REG_STAGE_LIMIT:   r_stage_lim <= i_cfg_wdata[3:0];
                REG_CACHE_LENGTH:  r_cache_len <= i_cfg_wdata;
                REG_BASE_BAN_LEN:  r_base      <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    logic [2:0]       r_state;
    logic [63:0]      r_ah, r_al;
    logic [31:0]      r_now;
    logic [CNT_W-1:0] r_idx;
    logic             r_v1, r_v2;
    logic [IDX_W-1:0] r_p1, r_p2;
    t_entry           r_rd, r_e2, r_e;
    logic [31:0]      r_len;
    logic             r_hit, r_spare;
    logic [IDX_W-1:0] r_hit_idx, r_spare_idx;
    logic [ENTRIES-1:0] r_valid;

    // Result staging and output register.
    logic        r_thr, r_deny, r_full;
    logic [31:0] r_dlen;
    logic [3:0]  r_stg;
    logic        r_out_vld;
    logic [39:0] r_out;

    // Entry memory.
    t_entry r_mem [ENTRIES];
    logic   mem_we;
    t_entry w_e;
    logic [IDX_W-1:0] rd_addr;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[r_hit_idx] <= w_e;
        r_rd <= r_mem[rd_addr];
    end
    assign rd_addr = r_idx[IDX_W-1:0];

    // Shared ban length multiplier.
    logic [3:0]  mul_stage;
    logic [31:0] mul_len;
    assign mul_stage = (r_state == ST_SCAN) ? r_rd.ban_stage : r_e.ban_stage;

    pact_lenmul #(.MAX_STAGES(MAX_STAGES)) u_lenmul (
        .i_clk   (i_clk),
        .i_base  (r_base),
        .i_stage (mul_stage),
        .o_len   (mul_len)
    );

    // Liveness and match of the entry in the second scan stage.
    logic live2, match2;
    always_comb begin
        live2 = r_valid[r_p2] &&
                ((r_now < r_e2.expiry_time) ||
                 ((r_e2.ban_time != 32'd0) &&
                  ($signed({2'b00, r_now}) - $signed({2'b00, r_e2.ban_time})
                   <= $signed({2'b00, mul_len}))));
        match2 = (r_e2.key_high == r_ah) && (r_e2.key_low == r_al);
    end

    // First update step: window, ban expiry, attempt count and, on a trigger, ban start and stage raise.
    t_entry u1;
    logic   u1_trig;
    logic [3:0] lim;
    always_comb begin
        u1 = r_e;
        if ($signed({2'b00, r_now}) - $signed({2'b00, u1.window_start})
            > $signed({18'd0, r_trig_span})) begin
            u1.window_start  = r_now;
            u1.attempt_count = 8'd0;
        end
        if ((u1.ban_time != 32'd0) &&
            ({1'b0, u1.ban_time} + {1'b0, r_len} < {1'b0, r_now})) begin
            u1.ban_time      = 32'd0;
            u1.window_start  = r_now;
            u1.attempt_count = 8'd0;
            u1.expiry_time   = pact_sat_add(r_now, {12'd0, r_cache_len});
        end
        u1.attempt_count = u1.attempt_count + 8'd1;
        u1_trig = !(u1.attempt_count < r_trig_cnt);
        lim = r_stage_lim;
        if (lim < 4'd1) lim = 4'd1;
        if (lim > MAX_S) lim = MAX_S;
        if (u1_trig) begin
            if (u1.ban_time == 32'd0) begin
                u1.ban_time  = r_now;
                u1.ban_stage = 4'd0;
            end
            u1.window_start  = 32'd0;
            u1.attempt_count = 8'd0;
            if (u1.ban_stage < lim) u1.ban_stage = u1.ban_stage + 4'd1;
        end
    end

    // Write-back data: the updated entry, or after a trigger the entry with the
    // expiry pushed out past a ban longer than the cache time.
    always_comb begin
        w_e = u1;
        if (r_state == ST_UPD3) begin
            w_e = r_e;
            if (mul_len > {12'd0, r_cache_len})
                w_e.expiry_time = pact_sat_add(r_now, mul_len);
        end
    end

    assign mem_we = ((r_state == ST_UPD1) && !u1_trig) || (r_state == ST_UPD3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_valid   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if ((r_state == ST_OUT) && (!r_out_vld || i_m_axis_tready))
                r_out_vld <= 1'b1;
            else if (r_out_vld && i_m_axis_tready)
                r_out_vld <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_ah    <= i_s_axis_tdata[63:0];
                        r_al    <= i_s_axis_tdata[127:64];
                        r_now   <= i_s_axis_tdata[159:128];
                        r_idx   <= '0;
                        r_hit   <= 1'b0;
                        r_spare <= 1'b0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_v1 <= (r_idx != LAST_CNT);
                    r_p1 <= rd_addr;
                    if (r_idx != LAST_CNT) r_idx <= r_idx + CNT_W'(1);
                    r_v2 <= r_v1;
                    r_p2 <= r_p1;
                    r_e2 <= r_rd;
                    if (r_v2) begin
                        if (!live2) begin
                            r_valid[r_p2] <= 1'b0;
                            if (!r_spare) begin
                                r_spare     <= 1'b1;
                                r_spare_idx <= r_p2;
                            end
                        end else if (!r_hit && match2) begin
                            r_hit     <= 1'b1;
                            r_hit_idx <= r_p2;
                            r_e       <= r_e2;
                            r_len     <= mul_len;
                        end
                    end
                    if ((r_idx == LAST_CNT) && !r_v1 && !r_v2) r_state <= ST_DEC;
                end
                ST_DEC: begin
                    if (r_hit) begin
                        r_state <= ST_UPD1;
                    end else if (r_spare) begin
                        r_hit_idx            <= r_spare_idx;
                        r_valid[r_spare_idx] <= 1'b1;
                        r_e.key_high         <= r_ah;
                        r_e.key_low          <= r_al;
                        r_e.window_start     <= 32'd0;
                        r_e.attempt_count    <= 8'd0;
                        r_e.ban_time         <= 32'd0;
                        r_e.ban_stage        <= 4'd0;
                        r_e.expiry_time      <= pact_sat_add(r_now, {12'd0, r_cache_len});
                        r_len                <= {16'd0, r_base};
                        r_state              <= ST_UPD1;
                    end else begin
                        r_thr   <= 1'b0;
                        r_deny  <= 1'b0;
                        r_dlen  <= 32'd0;
                        r_stg   <= 4'd0;
                        r_full  <= 1'b1;
                        r_state <= ST_OUT;
                    end
                end
                ST_UPD1: begin
                    r_e    <= u1;
                    r_full <= 1'b0;
                    if (u1_trig) begin
                        r_state <= ST_UPD2;
                    end else begin
                        r_thr   <= (u1.ban_time != 32'd0);
                        r_deny  <= 1'b0;
                        r_dlen  <= 32'd0;
                        r_stg   <= u1.ban_stage;
                        r_state <= ST_OUT;
                    end
                end
                ST_UPD2: begin
                    r_state <= ST_UPD3;
                end
                ST_UPD3: begin
                    r_thr <= 1'b1;
                    r_stg <= r_e.ban_stage;
                    if ({1'b0, r_e.ban_time} + {1'b0, mul_len} >= {1'b0, r_now}) begin
                        r_deny <= 1'b1;
                        r_dlen <= mul_len;
                    end else begin
                        r_deny <= 1'b0;
                        r_dlen <= 32'd0;
                    end
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (!r_out_vld || i_m_axis_tready) begin
                        r_out   <= {1'b0, r_full, r_stg, r_dlen, r_deny, r_thr};
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out;

    a_deny_thr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (!r_out[1] || r_out[0]))
        else $error("deny without throttle");
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out[38]) |-> (r_out[37:0] == 38'd0))
        else $error("table full result carries data");
    a_len_deny: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out[1]) |-> (r_out[33:2] == 32'd0))
        else $error("deny length without deny");
    a_stage_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out[37:34] <= MAX_S))
        else $error("stage above maximum");

endmodule

[tb/tb_top.sv]
// Self-checking bench for the per-address connect throttle: a scoreboard class
// predicts every attempt's verdict, plain tasks drive the request and config ports.
// Depends on pact_pkg and per_address_connect_throttle.
module tb_top;
    import pact_pkg::*;

    typedef struct {
        logic        throttled;
        logic        deny_add;
        logic [31:0] deny_length;
        logic [3:0]  stage_now;
        logic        table_full;
    } t_verdict;

    class throttle_scoreboard;
        logic [7:0]  trig_count;
        logic [15:0] trig_span;
        logic [3:0]  stage_lim;
        logic [19:0] cache_len;
        logic [15:0] base_len;
        logic        live_bit [DEF_ENTRIES];
        t_entry      slot [DEF_ENTRIES];
        t_verdict    verdicts [$];
        int          errors;

        function new();
            trig_count = RST_TRIGGER_COUNT;
            trig_span  = RST_TRIGGER_SPAN;
            stage_lim  = RST_STAGE_LIMIT;
            cache_len  = RST_CACHE_LENGTH;
            base_len   = RST_BASE_BAN_LEN;
            foreach (live_bit[i]) live_bit[i] = 1'b0;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [19:0] val);
            case (idx)
                REG_TRIGGER_COUNT: trig_count = val[7:0];
                REG_TRIGGER_SPAN:  trig_span  = val[15:0];
                REG_STAGE_LIMIT:   stage_lim  = val[3:0];
                REG_CACHE_LENGTH:  cache_len  = val;
                REG_BASE_BAN_LEN:  base_len   = val[15:0];
                default: ;
            endcase
        endfunction

        function longint ban_seconds(logic [3:0] s);
            longint f;
            int c;
            f = 1;
            c = (s < 1) ? 1 : s;
            if (c > DEF_MAX_STAGES) c = DEF_MAX_STAGES;
            for (int k = 2; k <= c; k++) f = f * k;
            return longint'(base_len) * f;
        endfunction

        function logic [31:0] sat_add(logic [31:0] a, longint b);
            longint r;
            r = longint'(a) + b;
            return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
        endfunction

        function bit alive(int i, logic [31:0] now);
            if (!live_bit[i]) return 0;
            if (now < slot[i].expiry_time) return 1;
            if (slot[i].ban_time != 0 && longint'(now) - longint'(slot[i].ban_time)
                    <= ban_seconds(slot[i].ban_stage))
                return 1;
            return 0;
        endfunction

        function void note_request(logic [63:0] ah, logic [63:0] al, logic [31:0] now);
            t_verdict v;
            int hit, spare;
            longint tnow, len, lim;
            hit = -1;
            spare = -1;
            tnow = longint'(now);
            v = '{1'b0, 1'b0, 32'd0, 4'd0, 1'b0};
            for (int i = 0; i < DEF_ENTRIES; i++) begin
                if (!alive(i, now)) begin
                    live_bit[i] = 1'b0;
                    if (spare < 0) spare = i;
                end else if (hit < 0 && slot[i].key_high == ah && slot[i].key_low == al) begin
                    hit = i;
                end
            end
            if (hit < 0) begin
                if (spare < 0) begin
                    v.table_full = 1'b1;
                    verdicts.push_back(v);
                    return;
                end
                hit = spare;
                live_bit[hit] = 1'b1;
                slot[hit] = '0;
                slot[hit].key_high = ah;
                slot[hit].key_low = al;
                slot[hit].expiry_time = sat_add(now, longint'(cache_len));
            end
            if (tnow - longint'(slot[hit].window_start) > longint'(trig_span)) begin
                slot[hit].window_start = now;
                slot[hit].attempt_count = 0;
            end
            if (slot[hit].ban_time != 0 && longint'(slot[hit].ban_time)
                    + ban_seconds(slot[hit].ban_stage) < tnow) begin
                slot[hit].ban_time = 0;
                slot[hit].window_start = now;
                slot[hit].attempt_count = 0;
                slot[hit].expiry_time = sat_add(now, longint'(cache_len));
            end
            slot[hit].attempt_count = slot[hit].attempt_count + 8'd1;
            if (slot[hit].attempt_count < trig_count) begin
                v.throttled = (slot[hit].ban_time != 0);
                v.stage_now = slot[hit].ban_stage;
                verdicts.push_back(v);
                return;
            end
            if (slot[hit].ban_time == 0) begin
                slot[hit].ban_time = now;
                slot[hit].ban_stage = 0;
            end
            slot[hit].window_start = 0;
            slot[hit].attempt_count = 0;
            lim = (stage_lim < 1) ? 1 : stage_lim;
            if (lim > DEF_MAX_STAGES) lim = DEF_MAX_STAGES;
            if (slot[hit].ban_stage < lim) slot[hit].ban_stage++;
            len = ban_seconds(slot[hit].ban_stage);
            if (len > longint'(cache_len)) slot[hit].expiry_time = sat_add(now, len);
            v.throttled = 1'b1;
            if (longint'(slot[hit].ban_time) + len >= tnow) begin
                v.deny_add = 1'b1;
                v.deny_length = (len > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : len[31:0];
            end
            v.stage_now = slot[hit].ban_stage;
            verdicts.push_back(v);
        endfunction

        function void check_result(logic [39:0] d);
            t_verdict e;
            if (verdicts.size() == 0) begin
                $error("result with no request outstanding: %h", d);
                errors++;
                return;
            end
            e = verdicts.pop_front();
            if (d[0] !== e.throttled) begin
                $error("throttled: expected %0d, got %0d", e.throttled, d[0]);
                errors++;
            end
            if (d[1] !== e.deny_add) begin
                $error("deny_add: expected %0d, got %0d", e.deny_add, d[1]);
                errors++;
            end
            if (d[33:2] !== e.deny_length) begin
                $error("deny_length: expected %0d, got %0d", e.deny_length, d[33:2]);
                errors++;
            end
            if (d[37:34] !== e.stage_now) begin
                $error("stage_now: expected %0d, got %0d", e.stage_now, d[37:34]);
                errors++;
            end
            if (d[38] !== e.table_full) begin
                $error("table_full: expected %0d, got %0d", e.table_full, d[38]);
                errors++;
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_valid;
    logic         s_ready;
    logic [159:0] s_data;
    logic         m_valid;
    logic         m_ready;
    logic [39:0]  m_data;
    logic         cfg_we;
    logic [2:0]   cfg_addr;
    logic [19:0]  cfg_wdata;

    throttle_scoreboard sb;
    int          hold_cycles;
    logic [31:0] clock_now;
    logic [63:0] pool_high [8];
    logic [63:0] pool_low [8];

    per_address_connect_throttle uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("FAIL");
        $finish;
    end

    // Both monitors run in the active region of the edge, before the block updates.
    always @(posedge i_clk) begin
        if (i_rst_n && s_valid && s_ready)
            sb.note_request(s_data[63:0], s_data[127:64], s_data[159:128]);
        if (i_rst_n && m_valid && m_ready)
            sb.check_result(m_data);
    end

    // Receiver: a long hold-off when asked, otherwise a stall pattern in one of
    // four randomly chosen modes.
    initial begin
        int mode;
        int cnt;
        mode = 0;
        cnt = 0;
        forever begin
            @(negedge i_clk);
            if (cnt == 0) begin
                mode = $urandom_range(0, 3);
                cnt = 100;
            end
            cnt--;
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 1) == 1);
                    2: m_ready <= ($urandom_range(0, 9) == 0);
                    default: m_ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    task automatic send_request(logic [63:0] ah, logic [63:0] al, logic [31:0] now);
        @(negedge i_clk);
        s_valid <= 1'b1;
        s_data <= {now, al, ah};
        do @(posedge i_clk); while (!s_ready);
    endtask

    task automatic pause_sender(int n);
        @(negedge i_clk);
        s_valid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic drain();
        pause_sender(1);
        while (sb.verdicts.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [19:0] val);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        sb.write_reg(idx, val);
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(logic [7:0] tc, logic [15:0] ts, logic [3:0] sl,
                             logic [19:0] cl, logic [15:0] bl);
        drain();
        write_reg(REG_TRIGGER_COUNT, 20'(tc));
        write_reg(REG_TRIGGER_SPAN, 20'(ts));
        write_reg(REG_STAGE_LIMIT, 20'(sl));
        write_reg(REG_CACHE_LENGTH, cl);
        write_reg(REG_BASE_BAN_LEN, 20'(bl));
    endtask

    task automatic refresh_pool();
        foreach (pool_high[k]) begin
            pool_high[k] = {$urandom, $urandom};
            pool_low[k] = {$urandom, $urandom};
        end
    endtask

    // Repeat offenders from a small pool mixed with fresh addresses at the given
    // percentage, time creeping forward, plus time jumps, backward steps and arbitrary times.
    task automatic random_attempts(int n, int fresh_pct);
        int burst;
        int k;
        logic [63:0] ah, al;
        burst = 0;
        for (int j = 0; j < n; j++) begin
            if (burst == 0) begin
                if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 30));
                burst = $urandom_range(1, 40);
            end
            burst--;
            case ($urandom_range(0, 19))
                0:       clock_now = $urandom;
                1:       clock_now = clock_now + $urandom_range(100, 20000);
                2:       clock_now = clock_now - $urandom_range(1, 30);
                default: clock_now = clock_now + $urandom_range(0, 4);
            endcase
            if ($urandom_range(0, 99) < fresh_pct) begin
                ah = {$urandom, $urandom};
                al = {$urandom, $urandom};
            end else begin
                k = $urandom_range(0, 7);
                ah = pool_high[k];
                al = pool_low[k];
            end
            send_request(ah, al, clock_now);
        end
    endtask

    initial begin
        sb = new();
        hold_cycles = 0;
        i_rst_n = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        clock_now = 32'd5000;
        refresh_pool();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: a ban, a throttled attempt while banned, a stage raise,
        // ban expiry, time going backwards and the extreme fields.
        for (int j = 0; j < 3; j++) send_request(64'd1, 64'd2, 32'd1000 + j);
        send_request(64'd1, 64'd2, 32'd1003);
        send_request(64'd1, 64'd2, 32'd1004);
        send_request(64'd1, 64'd2, 32'd1005);
        send_request(64'd1, 64'd2, 32'd990);
        send_request(64'd1, 64'd2, 32'd9000);
        send_request('0, '0, 32'd0);
        send_request('0, '0, 32'd0);
        send_request('0, '0, 32'd0);
        send_request('1, '1, 32'hFFFF_FFFF);
        send_request('1, '1, 32'hFFFF_FFFF);
        send_request('1, '1, 32'hFFFF_FFF0);
        send_request('1, '1, 32'hFFFF_FFFE);
        send_request(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA);
        send_request(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555);

        // The sender keeps offering while the receiver holds off for a long time.
        drain();
        hold_cycles = 400;
        for (int j = 0; j < 20; j++) send_request(pool_high[0], pool_low[0], clock_now + j);
        clock_now = clock_now + 20;
        drain();

        random_attempts(250, 10);

        configure(8'd1, 16'd0, 4'd1, 20'd1, 16'd1);
        refresh_pool();
        random_attempts(200, 10);

        configure(8'd255, 16'd65535, 4'd8, 20'hFFFFF, 16'd65535);
        refresh_pool();
        random_attempts(150, 5);

        // Trigger count zero and stage limit zero.
        configure(8'd0, 16'd7, 4'd0, 20'd50, 16'd3);
        refresh_pool();
        random_attempts(200, 10);

        // Stage limit above the largest stage, long bans from the largest base length.
        configure(8'd2, 16'd20, 4'd15, 20'd1000, 16'd65535);
        refresh_pool();
        random_attempts(250, 10);

        // Long-lived entries with many fresh addresses fill the table.
        configure(8'd4, 16'd30, 4'd3, 20'hFFFFF, 16'd100);
        refresh_pool();
        random_attempts(250, 70);

        configure(8'($urandom_range(1, 6)), 16'($urandom_range(0, 60)),
                  4'($urandom_range(1, 8)), 20'($urandom_range(1, 5000)),
                  16'($urandom_range(1, 500)));
        refresh_pool();
        random_attempts(460, 15);

        drain();
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.verdicts.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

[sim.f]
sv/pact_pkg.sv
sv/pact_lenmul.sv
sv/per_address_connect_throttle.sv
tb/tb_top.sv
